/* rtl/tep_pkg.sv */
// shared types and constants of the timed event priority queue
// no dependencies
package tep_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_TIME_BITS   = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int DATA_W          = 32;
    localparam int KIND_W          = 2;
    localparam int REQ_W           = 3;
    localparam int COUNT_PORT_W    = 6;

    localparam logic [REQ_W-1:0] REQ_ADD_ABS  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_DLY  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADVANCE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_PROC = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PROCESS  = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] object;
        logic [DATA_W-1:0] payload;
    } t_event;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_cmd;

endpackage

/* rtl/tep_cell.sv */
// one slot of the sorted event chain: holds an event and its due tick
// depends on tep_pkg
module tep_cell #(
    parameter int TIME_BITS = tep_pkg::DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  tep_pkg::t_cell_cmd   i_cmd,
    input  logic                 i_occ,
    input  logic [TIME_BITS-1:0] i_new_due,
    input  tep_pkg::t_event      i_new_evt,
    input  logic                 i_left_before,
    input  logic [TIME_BITS-1:0] i_left_due,
    input  tep_pkg::t_event      i_left_evt,
    input  logic [TIME_BITS-1:0] i_right_due,
    input  tep_pkg::t_event      i_right_evt,
    output logic                 o_before,
    output logic [TIME_BITS-1:0] o_due,
    output tep_pkg::t_event      o_evt
);

    logic [TIME_BITS-1:0] r_due;
    tep_pkg::t_event      r_evt;
    logic [TIME_BITS-1:0] n_due;
    tep_pkg::t_event      n_evt;

    // new word sorts ahead of this slot; equal ticks keep arrival order
    assign o_before = !i_occ || (i_new_due < r_due);

    always_comb begin
        n_due = r_due;
        n_evt = r_evt;
        if (i_cmd.ins && o_before) begin
            if (i_left_before) begin
                n_due = i_left_due;
                n_evt = i_left_evt;
            end else begin
                n_due = i_new_due;
                n_evt = i_new_evt;
            end
        end else if (i_cmd.pop) begin
            n_due = i_right_due;
            n_evt = i_right_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_due <= n_due;
        r_evt <= n_evt;
    end

    assign o_due = r_due;
    assign o_evt = r_evt;

endmodule

/* rtl/timed_event_priority_queue_top.sv */
// timed event priority queue: request decode, time keeping and the cell chain
// depends on tep_pkg and tep_cell
//
// A request is taken when start is high and busy is low. Every request gives
// one or more results, each shown for one cycle with o_strobe high; the
// receiver cannot stall them. Pending events sit in a chain of QUEUE_DEPTH
// cells kept sorted by due tick, earliest at the head, equal ticks in
// arrival order.
// Add, add-after-delay, advance and unused codes: the result appears in the
// cycle after acceptance and busy stays low, so one request per cycle.
// An add shifts the chain to take in the word; a full chain drops the word
// and flags o_overflow.
// Process (with or without setting the time): busy is high in ST_PROC,
// left with the last due event, or without a pop when none is due; one
// due event leaves the chain head per cycle, so n results follow back to
// back, each registered at the outputs once ST_PROC is entered (n up to
// 32), the last with o_last_of_run high. With no due event a single invalid
// result is given. Rate is set by the one-pop-per-cycle shift of the chain.
// Synchronous active-low reset empties the queue and zeroes the time; cell
// contents are not cleared.
module timed_event_priority_queue_top #(
    parameter int QUEUE_DEPTH = tep_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = tep_pkg::DEF_TIME_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tep_pkg::REQ_W-1:0]        i_req_type,
    input  logic [tep_pkg::KIND_W-1:0]       i_event_kind,
    input  logic [tep_pkg::DATA_W-1:0]       i_object_id,
    input  logic [tep_pkg::DATA_W-1:0]       i_time_value,
    input  logic [tep_pkg::DATA_W-1:0]       i_payload_tag,
    output logic                             o_strobe,
    output logic                             o_event_valid,
    output logic [tep_pkg::KIND_W-1:0]       o_out_kind,
    output logic [tep_pkg::DATA_W-1:0]       o_out_object,
    output logic [tep_pkg::DATA_W-1:0]       o_out_payload,
    output logic [tep_pkg::DATA_W-1:0]       o_out_due_time,
    output logic                             o_last_of_run,
    output logic [tep_pkg::DATA_W-1:0]       o_now_time,
    output logic [tep_pkg::COUNT_PORT_W-1:0] o_pending_count,
    output logic                             o_overflow
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RUN_W = $clog2(tep_pkg::MAX_RESULTS);
    localparam int SUM_W = ((TIME_BITS > tep_pkg::DATA_W) ? TIME_BITS : tep_pkg::DATA_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic {
        ST_IDLE,
        ST_PROC
    } t_state;

    t_state                           r_state, n_state;
    logic [TIME_BITS-1:0]             r_now, n_now;
    logic [CNT_W-1:0]                 r_count, n_count;
    logic [RUN_W-1:0]                 r_runs, n_runs;
    logic                             r_strobe, n_strobe;
    logic                             r_valid, n_valid;
    tep_pkg::t_event                  r_evt, n_evt;
    logic [TIME_BITS-1:0]             r_due, n_due;
    logic                             r_last, n_last;
    logic                             r_ovf, n_ovf;

    tep_pkg::t_cell_cmd               cmd;
    logic [TIME_BITS-1:0]             new_due;
    tep_pkg::t_event                  new_evt;
    logic [QUEUE_DEPTH-1:0]           occ;
    logic [QUEUE_DEPTH-1:0]           ahead;
    logic [TIME_BITS-1:0]             cell_due [QUEUE_DEPTH];
    tep_pkg::t_event                  cell_evt [QUEUE_DEPTH];

    logic                             accept;
    logic                             full;
    logic [TIME_BITS-1:0]             tv_clamp;
    logic [TIME_BITS-1:0]             now_plus;
    logic [SUM_W-1:0]                 sum;
    logic                             head_due;
    logic                             next_due;

    assign accept = start && (r_state == ST_IDLE);
    assign full   = (r_count == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        if (SUM_W'(i_time_value) > SUM_W'(TIME_MAX)) begin
            tv_clamp = TIME_MAX;
        end else begin
            tv_clamp = TIME_BITS'(i_time_value);
        end
        sum = SUM_W'(r_now) + SUM_W'(i_time_value);
        if (sum > SUM_W'(TIME_MAX)) begin
            now_plus = TIME_MAX;
        end else begin
            now_plus = TIME_BITS'(sum);
        end
    end

    assign new_due = (i_req_type == tep_pkg::REQ_ADD_DLY) ? now_plus : tv_clamp;
    assign new_evt = '{kind: i_event_kind, object: i_object_id, payload: i_payload_tag};

    // next-in-line is checked so the last result of a run is known as it leaves
    assign head_due = (r_count != '0) && (cell_due[0] <= r_now);
    generate
        if (QUEUE_DEPTH > 1) begin : g_next
            assign next_due = (r_count > CNT_W'(1)) && (cell_due[1] <= r_now)
                           && (r_runs != RUN_W'(tep_pkg::MAX_RESULTS - 1));
        end else begin : g_no_next
            assign next_due = 1'b0;
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_now    = r_now;
        n_count  = r_count;
        n_runs   = r_runs;
        n_strobe = 1'b0;
        n_valid  = 1'b0;
        n_evt    = '0;
        n_due    = '0;
        n_last   = 1'b1;
        n_ovf    = 1'b0;
        cmd      = '{ins: 1'b0, pop: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        tep_pkg::REQ_ADD_ABS, tep_pkg::REQ_ADD_DLY: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                cmd.ins = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        tep_pkg::REQ_ADVANCE: begin
                            n_strobe = 1'b1;
                            n_now    = now_plus;
                        end
                        tep_pkg::REQ_SET_PROC: begin
                            n_now   = tv_clamp;
                            n_runs  = '0;
                            n_state = ST_PROC;
                        end
                        tep_pkg::REQ_PROCESS: begin
                            n_runs  = '0;
                            n_state = ST_PROC;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_PROC: begin
                n_strobe = 1'b1;
                if (head_due) begin
                    cmd.pop = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    n_valid = 1'b1;
                    n_evt   = cell_evt[0];
                    n_due   = cell_due[0];
                    n_last  = !next_due;
                    n_runs  = r_runs + RUN_W'(1);
                    if (!next_due) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            logic                 left_before;
            logic [TIME_BITS-1:0] left_due;
            tep_pkg::t_event      left_evt;
            logic [TIME_BITS-1:0] right_due;
            tep_pkg::t_event      right_evt;

            assign occ[i] = (CNT_W'(i) < r_count);

            if (i == 0) begin : g_first
                assign left_before = 1'b0;
                assign left_due    = cell_due[0];
                assign left_evt    = cell_evt[0];
            end else begin : g_mid
                assign left_before = ahead[i-1];
                assign left_due    = cell_due[i-1];
                assign left_evt    = cell_evt[i-1];
            end

            if (i == QUEUE_DEPTH - 1) begin : g_last
                assign right_due = cell_due[i];
                assign right_evt = cell_evt[i];
            end else begin : g_inner
                assign right_due = cell_due[i+1];
                assign right_evt = cell_evt[i+1];
            end

            tep_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_occ        (occ[i]),
                .i_new_due    (new_due),
                .i_new_evt    (new_evt),
                .i_left_before(left_before),
                .i_left_due   (left_due),
                .i_left_evt   (left_evt),
                .i_right_due  (right_due),
                .i_right_evt  (right_evt),
                .o_before     (ahead[i]),
                .o_due        (cell_due[i]),
                .o_evt        (cell_evt[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_now    <= '0;
            r_count  <= '0;
            r_runs   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_count  <= n_count;
            r_runs   <= n_runs;
            r_strobe <= n_strobe;
        end
        r_valid <= n_valid;
        r_evt   <= n_evt;
        r_due   <= n_due;
        r_last  <= n_last;
        r_ovf   <= n_ovf;
    end

    assign busy            = (r_state == ST_PROC);
    assign o_strobe        = r_strobe;
    assign o_event_valid   = r_valid;
    assign o_out_kind      = r_evt.kind;
    assign o_out_object    = r_evt.object;
    assign o_out_payload   = r_evt.payload;
    assign o_out_due_time  = tep_pkg::DATA_W'(r_due);
    assign o_last_of_run   = r_last;
    assign o_now_time      = tep_pkg::DATA_W'(r_now);
    assign o_pending_count = tep_pkg::COUNT_PORT_W'(r_count);
    assign o_overflow      = r_ovf;

endmodule
